FILE: rtl/core/p2c_pkg.sv
// ----------------------------------------------------------------------------
// p2c_pkg
// Shared types and constants of the planar to chunky converter.
// ----------------------------------------------------------------------------
`default_nettype none

package p2c_pkg;

	localparam int unsigned DEF_IMAGE_WIDTH  = 32;
	localparam int unsigned DEF_IMAGE_HEIGHT = 29;
	localparam int unsigned DEF_PLANE_COUNT  = 4;
	localparam int unsigned DEF_QUEUE_DEPTH  = 4;

	localparam int unsigned PIX_W   = 4;
	localparam int unsigned IDX_W   = 10;
	localparam int unsigned OUT_W   = 16;
	localparam int unsigned BIT_W   = 3;

	typedef struct packed {
		logic [PIX_W-1:0][7:0] planes;
		logic [IDX_W-1:0]      idx_base;
		logic                  last_img;
	} p2c_entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/p2c_front.sv
// ----------------------------------------------------------------------------
// p2c_front
// Byte intake: position tracking, plane store and gathering of one byte group.
// ----------------------------------------------------------------------------
`default_nettype none

module p2c_front
	import p2c_pkg::*;
#(
	parameter int unsigned IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
	parameter int unsigned IMAGE_HEIGHT = DEF_IMAGE_HEIGHT,
	parameter int unsigned PLANE_COUNT  = DEF_PLANE_COUNT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_start,
	output      logic       push,
	output      p2c_entry_t push_data,
	input  wire logic       q_full
);

	localparam int unsigned ROW_BYTES   = IMAGE_WIDTH / 8;
	localparam int unsigned PLANE_BYTES = ROW_BYTES * IMAGE_HEIGHT;
	localparam int unsigned COL_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
	localparam int unsigned OFF_W = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;
	localparam int unsigned PL_W  = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
	localparam int unsigned STORED = (PLANE_COUNT - 1 < PIX_W) ? PLANE_COUNT - 1 : PIX_W;

	logic [PL_W-1:0]  plane_q;
	logic [OFF_W-1:0] offset_q;
	logic [COL_W-1:0] col_q;
	logic [IDX_W-1:0] row_base_q;

	logic [PL_W-1:0]  cur_plane;
	logic [OFF_W-1:0] cur_offset;
	logic [COL_W-1:0] cur_col;
	logic [IDX_W-1:0] cur_row_base;
	logic             accept;
	logic             is_last_plane;
	logic             plane_end;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [IDX_W-1:0] idx_base_s1;
	logic             last_img_s1;

	assign in_ready      = !valid_s1 || !q_full;
	assign accept        = in_valid && in_ready;
	assign push          = valid_s1 && !q_full;

	assign cur_plane     = in_start ? '0 : plane_q;
	assign cur_offset    = in_start ? '0 : offset_q;
	assign cur_col       = in_start ? '0 : col_q;
	assign cur_row_base  = in_start ? '0 : row_base_q;
	assign is_last_plane = (cur_plane == PL_W'(PLANE_COUNT - 1));
	assign plane_end     = (cur_offset == OFF_W'(PLANE_BYTES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q    <= '0;
			offset_q   <= '0;
			col_q      <= '0;
			row_base_q <= '0;
		end else if (accept) begin
			if (plane_end) begin
				offset_q   <= '0;
				col_q      <= '0;
				row_base_q <= '0;
				plane_q    <= is_last_plane ? '0 : cur_plane + PL_W'(1);
			end else begin
				plane_q  <= cur_plane;
				offset_q <= cur_offset + OFF_W'(1);
				if (cur_col == COL_W'(ROW_BYTES - 1)) begin
					col_q      <= '0;
					row_base_q <= cur_row_base + IDX_W'(IMAGE_WIDTH);
				end else begin
					col_q      <= cur_col + COL_W'(1);
					row_base_q <= cur_row_base;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= is_last_plane;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_last_plane) begin
			byte_s1     <= in_byte;
			idx_base_s1 <= cur_row_base + IDX_W'({cur_col, 3'b000});
			last_img_s1 <= plane_end;
		end
	end

	for (genvar p = 0; p < PIX_W; p++) begin : g_plane
		if (p < STORED) begin : g_store
			logic [7:0] mem [PLANE_BYTES];
			logic [7:0] rd_s1;
			always_ff @(posedge clk) begin
				if (accept && cur_plane == PL_W'(p)) begin
					mem[cur_offset] <= in_byte;
				end
				if (accept && is_last_plane) begin
					rd_s1 <= mem[cur_offset];
				end
			end
			assign push_data.planes[p] = rd_s1;
		end else if (p == PLANE_COUNT - 1) begin : g_last
			assign push_data.planes[p] = byte_s1;
		end else begin : g_none
			assign push_data.planes[p] = '0;
		end
	end

	assign push_data.idx_base = idx_base_s1;
	assign push_data.last_img = last_img_s1;

endmodule

`default_nettype wire

FILE: rtl/core/p2c_queue.sv
// ----------------------------------------------------------------------------
// p2c_queue
// Small first-in first-out queue of byte groups between intake and output.
// ----------------------------------------------------------------------------
`default_nettype none

module p2c_queue
	import p2c_pkg::*;
#(
	parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire p2c_entry_t push_data,
	output      logic       full,
	input  wire logic       pop,
	output      logic       valid,
	output      p2c_entry_t pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	p2c_entry_t       slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/p2c_back.sv
// ----------------------------------------------------------------------------
// p2c_back
// Serialiser: turns one byte group into eight pixels behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module p2c_back
	import p2c_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire p2c_entry_t       q_data,
	output      logic             pop,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      logic [OUT_W-1:0] out_data,
	output      logic             out_last,
	output      logic             out_user
);

	p2c_entry_t       cur_q;
	logic             busy_q;
	logic [BIT_W-1:0] k_q;
	logic             adv;
	logic             final_bit;
	logic [PIX_W-1:0] value;
	logic [IDX_W-1:0] index;

	logic             m_valid_q;
	logic [OUT_W-1:0] m_data_q;
	logic             m_last_q;
	logic             m_user_q;

	assign final_bit = (k_q == BIT_W'(7));
	assign adv       = busy_q && (!m_valid_q || out_ready);
	assign pop       = q_valid && (!busy_q || (adv && final_bit));
	assign index     = cur_q.idx_base + IDX_W'(k_q);

	always_comb begin
		for (int p = 0; p < PIX_W; p++) begin
			value[p] = cur_q.planes[p][BIT_W'(7) - k_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else begin
			if (adv) begin
				k_q <= k_q + BIT_W'(1);
				if (final_bit) begin
					busy_q <= 1'b0;
				end
			end
			if (pop) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_data;
		end
		if (adv) begin
			m_data_q <= OUT_W'({index, value});
			m_last_q <= final_bit;
			m_user_q <= final_bit && cur_q.last_img;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (out_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign out_valid = m_valid_q;
	assign out_data  = m_data_q;
	assign out_last  = m_last_q;
	assign out_user  = m_user_q;

`ifndef SYNTH
	a_reload_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && busy_q) |-> (adv && final_bit))
		else $error("byte group replaced before its last pixel");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/planar_to_chunky_converter_unit.sv
// ----------------------------------------------------------------------------
// planar_to_chunky_converter_unit
// Bitplane planar image to chunky pixel converter.
// ----------------------------------------------------------------------------
// The slave channel takes the planar image one byte per transfer, plane 0
// first, rows in order; s_tuser high marks the first byte of a new image,
// otherwise the position wraps after the last byte of the last plane.
// Bytes of earlier planes go into an on-chip store and give no output. Each
// byte of the last plane is joined with the stored bytes at the same offset
// and gives eight pixel transfers on the master channel, leftmost first.
// The serialiser emits one pixel per cycle while the output register is
// empty or taken by the master; a queue of QUEUE_DEPTH byte groups lets
// intake run ahead of it. A last-plane byte passes the intake register, the
// queue and the group register before its pixels reach the output register.
// A stalled master holds the output register; the queue then fills and
// s_tready drops. Reset empties the queue and pipeline and returns the
// position to the first byte of plane 0; the store is not cleared, and
// needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_to_chunky_converter_unit
	import p2c_pkg::*;
#(
	parameter int unsigned IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
	parameter int unsigned IMAGE_HEIGHT = DEF_IMAGE_HEIGHT,
	parameter int unsigned PLANE_COUNT  = DEF_PLANE_COUNT,
	parameter int unsigned QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output      logic             s_tready,
	input  wire logic [7:0]       s_tdata,  // [7:0] plane_byte
	input  wire logic             s_tuser,  // [0] start_image
	output      logic             m_tvalid,
	input  wire logic             m_tready,
	output      logic [OUT_W-1:0] m_tdata,  // [3:0] pixel_value, [13:4] pixel_index
	output      logic             m_tlast,  // last_in_run
	output      logic             m_tuser   // [0] last_in_image
);

	logic       push;
	p2c_entry_t push_data;
	logic       q_full;
	logic       pop;
	logic       q_valid;
	p2c_entry_t q_data;

	p2c_front #(
		.IMAGE_WIDTH (IMAGE_WIDTH),
		.IMAGE_HEIGHT(IMAGE_HEIGHT),
		.PLANE_COUNT (PLANE_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_start (s_tuser),
		.push     (push),
		.push_data(push_data),
		.q_full   (q_full)
	);

	p2c_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.pop_data (q_data)
	);

	p2c_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata),
		.out_last (m_tlast),
		.out_user (m_tuser)
	);

endmodule

`default_nettype wire
